### rtl/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants for the largest empty rectangle core.
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

    localparam int HEIGHT_W     = 11;
    localparam int AREA_W       = 21;
    localparam int LEN_W        = 11;
    localparam int DEF_MAX_COLS = 1024;

    localparam logic [LEN_W-1:0]    ROW_LEN_RESET = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX    = 11'h7FF;
    localparam logic [AREA_W-1:0]   AREA_MAX      = 21'h1FFFFF;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HGT,
        S_POP,
        S_BEST,
        S_RELOAD
    } t_state;

    // controls for the area unit
    typedef struct packed {
        logic calc;
        logic fold;
        logic clear;
    } t_area_ctl;

endpackage

`default_nettype wire

### rtl/mer_area.sv
// ----------------------------------------------------------------------------
// mer_area
// Bar area multiplier with saturation and the running best area of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_area #(
    parameter int WIDTH_W = 11
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mer_pkg::t_area_ctl           i_ctl,
    input  wire logic [mer_pkg::HEIGHT_W-1:0] i_height,
    input  wire logic [WIDTH_W-1:0]           i_width,
    output logic      [mer_pkg::AREA_W-1:0]   o_best
);

    localparam int P_W = mer_pkg::HEIGHT_W + WIDTH_W;
    localparam int X_W = (P_W > mer_pkg::AREA_W) ? P_W : mer_pkg::AREA_W;

    logic [X_W-1:0]             prod;
    logic [mer_pkg::AREA_W-1:0] sat_area;
    logic [mer_pkg::AREA_W-1:0] r_area;
    logic [mer_pkg::AREA_W-1:0] r_best;

    always_comb begin
        prod = X_W'(i_height) * X_W'(i_width);
        if (prod > X_W'(mer_pkg::AREA_MAX)) begin
            sat_area = mer_pkg::AREA_MAX;
        end else begin
            sat_area = prod[mer_pkg::AREA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.calc) begin
            r_area <= sat_area;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (i_ctl.clear) begin
            r_best <= '0;
        end else if (i_ctl.fold && (r_area > r_best)) begin
            r_best <= r_area;
        end
    end

    assign o_best = r_best;

endmodule

`default_nettype wire

### rtl/max_empty_rectangle_core.sv
// ----------------------------------------------------------------------------
// max_empty_rectangle_core
// Streaming largest all-zero rectangle of a binary matrix, one cell per item,
// using per-column zero-run heights and a monotonic histogram stack in memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         i_valid / o_ready      i_cell_req, i_last_in_frame
//  result    out        o_valid / i_ready      o_max_area
//  config    in         i_cfg_we (no wait)     i_cfg_row_length
//
//  a cell passes through height read, height update and stack push, with a pop
//  and a best-area fold for every bar popped; a row end adds a stack reload and
//  a pop per bar left; the stack read port and area multiplier set these steps.
//  height store needs no clearing pass: a fill count masks columns not yet
//  written in the frame, so the core is ready right after reset.
//  a result waits in the output register; the core stalls only when a frame
//  ends while the previous result has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module max_empty_rectangle_core #(
    parameter int MAX_COLS = mer_pkg::DEF_MAX_COLS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_cell_req,
    input  wire logic                       i_last_in_frame,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [mer_pkg::AREA_W-1:0] o_max_area,
    input  wire logic                       i_cfg_we,
    input  wire logic [mer_pkg::LEN_W-1:0]  i_cfg_row_length
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int LW    = ((CNT_W > mer_pkg::LEN_W) ? CNT_W : mer_pkg::LEN_W) + 1;
    localparam int ENT_W = COL_W + mer_pkg::HEIGHT_W;

    // memories
    logic [mer_pkg::HEIGHT_W-1:0] hmem [MAX_COLS];
    logic [ENT_W-1:0]             smem [MAX_COLS];
    logic [mer_pkg::HEIGHT_W-1:0] r_hrd;
    logic [ENT_W-1:0]             r_srd;

    // control state
    mer_pkg::t_state              r_state, n_state;
    logic [COL_W-1:0]             r_col_idx;
    logic [CNT_W-1:0]             r_fill;
    logic [CNT_W-1:0]             r_depth;
    logic                         r_flush;
    logic                         r_last;
    logic                         r_out_valid;
    logic [mer_pkg::LEN_W-1:0]    r_row_len;

    // payload
    logic [COL_W-1:0]             r_col;
    logic                         r_cell;
    logic [mer_pkg::HEIGHT_W-1:0] r_h;
    logic [COL_W-1:0]             r_top_col;
    logic [mer_pkg::HEIGHT_W-1:0] r_top_h;
    logic [mer_pkg::AREA_W-1:0]   r_max_area;

    // datapath
    logic                         in_acc;
    logic                         out_free;
    logic [LW-1:0]                eff_len;
    logic                         end_row;
    logic [mer_pkg::HEIGHT_W-1:0] old_h;
    logic [mer_pkg::HEIGHT_W-1:0] new_h;
    logic [COL_W-1:0]             srd_col;
    logic [mer_pkg::HEIGHT_W-1:0] srd_h;
    logic [CNT_W-1:0]             left_edge;
    logic [CNT_W-1:0]             right_edge;
    logic [CNT_W-1:0]             bar_width;
    logic                         pop_go;
    logic                         push_go;
    logic                         flush_done;
    logic                         finish;
    logic                         s_ren;
    logic [COL_W-1:0]             s_raddr;
    logic                         h_ren;
    logic                         h_wen;
    logic                         s_wen;
    mer_pkg::t_area_ctl           area_ctl;
    logic [mer_pkg::AREA_W-1:0]   best;

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign {srd_col, srd_h} = r_srd;

    // row length 0 acts as 1, larger than the store acts as the store size
    always_comb begin
        if (r_row_len == '0) begin
            eff_len = LW'(1);
        end else if (LW'(r_row_len) > LW'(MAX_COLS)) begin
            eff_len = LW'(MAX_COLS);
        end else begin
            eff_len = LW'(r_row_len);
        end
        end_row = r_last || ((LW'(r_col) + LW'(1)) >= eff_len);
    end

    // columns at or past the fill count were not written this frame
    always_comb begin
        old_h = (CNT_W'(r_col) < r_fill) ? r_hrd : '0;
        if (r_cell) begin
            new_h = '0;
        end else if (old_h == mer_pkg::HEIGHT_MAX) begin
            new_h = old_h;
        end else begin
            new_h = old_h + 1'b1;
        end
    end

    always_comb begin
        left_edge  = (r_depth >= CNT_W'(2)) ? (CNT_W'(srd_col) + 1'b1) : '0;
        right_edge = r_flush ? (CNT_W'(r_col) + 1'b1) : CNT_W'(r_col);
        bar_width  = right_edge - left_edge;
        pop_go     = (r_depth != '0) && (r_flush || (r_top_h > r_h));
        push_go    = !pop_go && !r_flush;
        flush_done = r_flush && (r_depth == '0);
        finish     = flush_done && (!r_last || out_free);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mer_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = mer_pkg::S_HGT;
                end
            end
            mer_pkg::S_HGT: begin
                n_state = mer_pkg::S_POP;
            end
            mer_pkg::S_POP: begin
                if (pop_go) begin
                    n_state = mer_pkg::S_BEST;
                end else if (push_go) begin
                    n_state = end_row ? mer_pkg::S_RELOAD : mer_pkg::S_IDLE;
                end else if (finish) begin
                    n_state = mer_pkg::S_IDLE;
                end
            end
            mer_pkg::S_BEST: begin
                n_state = mer_pkg::S_POP;
            end
            mer_pkg::S_RELOAD: begin
                n_state = mer_pkg::S_POP;
            end
            default: begin
                n_state = mer_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_ready        = 1'b0;
        h_ren          = 1'b0;
        h_wen          = 1'b0;
        s_ren          = 1'b0;
        s_wen          = 1'b0;
        s_raddr        = COL_W'(r_depth - CNT_W'(2));
        area_ctl.calc  = 1'b0;
        area_ctl.fold  = 1'b0;
        area_ctl.clear = 1'b0;
        case (r_state)
            mer_pkg::S_IDLE: begin
                o_ready = 1'b1;
                h_ren   = in_acc;
                s_ren   = in_acc;
            end
            mer_pkg::S_HGT: begin
                h_wen = 1'b1;
            end
            mer_pkg::S_POP: begin
                if (pop_go) begin
                    area_ctl.calc = 1'b1;
                    s_ren         = 1'b1;
                    s_raddr       = COL_W'(r_depth - CNT_W'(3));
                end else if (push_go) begin
                    s_wen = (r_depth != '0);
                end else if (finish && r_last) begin
                    area_ctl.clear = 1'b1;
                end
            end
            mer_pkg::S_BEST: begin
                area_ctl.fold = 1'b1;
            end
            mer_pkg::S_RELOAD: begin
                s_ren = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // height store
    always_ff @(posedge i_clk) begin
        if (h_ren) begin
            r_hrd <= hmem[r_col_idx];
        end
        if (h_wen) begin
            hmem[r_col] <= new_h;
        end
    end

    // stack store: holds every entry below the top, which lives in registers
    always_ff @(posedge i_clk) begin
        if (s_ren) begin
            r_srd <= smem[s_raddr];
        end
        if (s_wen) begin
            smem[COL_W'(r_depth - CNT_W'(1))] <= {r_top_col, r_top_h};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mer_pkg::S_IDLE;
            r_col_idx   <= '0;
            r_fill      <= '0;
            r_depth     <= '0;
            r_flush     <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_len   <= mer_pkg::ROW_LEN_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_row_len <= i_cfg_row_length;
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_last  <= i_last_in_frame;
                r_flush <= 1'b0;
            end
            if (h_wen && (CNT_W'(r_col) >= r_fill)) begin
                r_fill <= CNT_W'(r_col) + 1'b1;
            end
            if (r_state == mer_pkg::S_POP) begin
                if (pop_go) begin
                    r_depth <= r_depth - 1'b1;
                end else if (push_go) begin
                    r_depth <= r_depth + 1'b1;
                    if (end_row) begin
                        r_flush <= 1'b1;
                    end else begin
                        r_col_idx <= r_col + 1'b1;
                    end
                end else if (finish) begin
                    r_col_idx <= '0;
                    if (r_last) begin
                        r_out_valid <= 1'b1;
                        r_fill      <= '0;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_col  <= r_col_idx;
            r_cell <= i_cell_req;
        end
        if (h_wen) begin
            r_h <= new_h;
        end
        if (r_state == mer_pkg::S_POP) begin
            if (pop_go) begin
                r_top_col <= srd_col;
                r_top_h   <= srd_h;
            end else if (push_go) begin
                r_top_col <= r_col;
                r_top_h   <= r_h;
            end else if (finish && r_last) begin
                r_max_area <= best;
            end
        end
    end

    mer_area #(
        .WIDTH_W (CNT_W)
    ) u_area (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (area_ctl),
        .i_height (r_top_h),
        .i_width  (bar_width),
        .o_best   (best)
    );

    assign o_valid    = r_out_valid;
    assign o_max_area = r_max_area;

endmodule

`default_nettype wire
